// ===== hdl/grvt_pkg.sv =====
`default_nettype none
package grvt_pkg;

  localparam int NUM_WINDOWS = 16;
  localparam int IDX_W       = 4;
  localparam int EYE_W       = 16;
  localparam int COORD_W     = 13;
  localparam int OFFSET_W    = 8;
  localparam int POINT_W     = 14;
  localparam int REGION_W    = 5;
  localparam int FLAGS_W     = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int SUM_W       = EYE_W + 1;
  localparam int PROD_W      = COORD_W + SUM_W;
  localparam int SCALE_SHIFT = 17;

  localparam logic signed [REGION_W-1:0] REGION_NONE = -5'sd1;

  localparam logic OP_SAMPLE      = 1'b0;
  localparam logic OP_TABLE_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_OFFSET  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDIT_MODE     = 2'd3;

  localparam logic [COORD_W-1:0]  RST_SCREEN_WIDTH  = 13'd1920;
  localparam logic [COORD_W-1:0]  RST_SCREEN_HEIGHT = 13'd1080;
  localparam logic [OFFSET_W-1:0] RST_POINT_OFFSET  = 8'd50;

  localparam int FLAG_ELIGIBLE = 0;
  localparam int FLAG_BUTTON   = 1;

  typedef struct packed {
    logic                       valid;
    logic signed [POINT_W-1:0]  x;
    logic signed [POINT_W-1:0]  y;
    logic signed [REGION_W-1:0] hit;
  } probe_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   index;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [FLAGS_W-1:0] flags;
  } tbl_wr_t;

endpackage
`default_nettype wire

// ===== hdl/grvt_if.sv =====
`default_nettype none
interface grvt_sample_if;
  import grvt_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [EYE_W-1:0]   left_eye_x;
  logic [EYE_W-1:0]   left_eye_y;
  logic [EYE_W-1:0]   right_eye_x;
  logic [EYE_W-1:0]   right_eye_y;
  logic [IDX_W-1:0]   entry_index;
  logic [COORD_W-1:0] win_left;
  logic [COORD_W-1:0] win_top;
  logic [COORD_W-1:0] win_width;
  logic [COORD_W-1:0] win_height;
  logic [FLAGS_W-1:0] win_flags;

  modport source (
    output valid, operation, left_eye_x, left_eye_y, right_eye_x, right_eye_y,
           entry_index, win_left, win_top, win_width, win_height, win_flags,
    input  ready
  );

  modport sink (
    input  valid, operation, left_eye_x, left_eye_y, right_eye_x, right_eye_y,
           entry_index, win_left, win_top, win_width, win_height, win_flags,
    output ready
  );
endinterface

interface grvt_result_if;
  import grvt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [POINT_W-1:0]  point_x;
  logic signed [POINT_W-1:0]  point_y;
  logic signed [REGION_W-1:0] hit_region;
  logic                       region_changed;
  logic signed [REGION_W-1:0] region_left;
  logic                       left_was_button;
  logic signed [REGION_W-1:0] region_entered;

  modport source (
    output valid, point_x, point_y, hit_region, region_changed, region_left,
           left_was_button, region_entered,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, hit_region, region_changed, region_left,
           left_was_button, region_entered,
    output ready
  );
endinterface
`default_nettype wire

// ===== hdl/gaze_region_vote_tracker.sv =====
`default_nettype none
// Gaze region tracker. Each sample transaction averages the two eyes' Q0.16
// gaze points into a screen point (scaled by the screen size, minus the point
// offset), walks that point down a row of sixteen window cells one cell per
// clock so that the lowest eligible window containing it is found, pushes the
// hit into a vote history and switches the current region when the new hit
// is seen at least MIN_REPEAT times. A sample passes the multiply, point,
// scan and vote states (edit mode skips the walk and vote); a window table
// write goes straight to the done state. One transaction is in work at a
// time; the result register lets the next one be accepted while a result
// still waits. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must do so only while the block is idle, as the block does not enforce it.
module gaze_region_vote_tracker #(
  parameter int HISTORY_DEPTH = 5,
  parameter int MIN_REPEAT    = 3
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [grvt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [grvt_pkg::CFG_DATA_W-1:0]     cfg_data,
  grvt_sample_if.sink                              sample,
  grvt_result_if.source                            result
);
  import grvt_pkg::*;

  localparam int VOTE_W = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_POINT = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_VOTE  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                     state;
  logic [COORD_W-1:0]         screen_width;
  logic [COORD_W-1:0]         screen_height;
  logic [OFFSET_W-1:0]        point_offset;
  logic                       edit_mode;

  logic [SUM_W-1:0]           sum_x;
  logic [SUM_W-1:0]           sum_y;
  logic [PROD_W-1:0]          prod_x;
  logic [PROD_W-1:0]          prod_y;
  logic signed [POINT_W-1:0]  px_calc;
  logic signed [POINT_W-1:0]  py_calc;

  logic signed [POINT_W-1:0]  res_px;
  logic signed [POINT_W-1:0]  res_py;
  logic signed [REGION_W-1:0] res_hit;
  logic                       res_changed;
  logic signed [REGION_W-1:0] res_left;
  logic                       res_button;
  logic signed [REGION_W-1:0] current_region;

  logic                       out_valid;
  logic signed [POINT_W-1:0]  out_px;
  logic signed [POINT_W-1:0]  out_py;
  logic signed [REGION_W-1:0] out_hit;
  logic                       out_changed;
  logic signed [REGION_W-1:0] out_left;
  logic                       out_button;
  logic signed [REGION_W-1:0] out_entered;

  logic                       accept;
  logic                       load;
  tbl_wr_t                    wr;
  probe_t                     chain [NUM_WINDOWS+1];
  logic [FLAGS_W-1:0]         kinds [NUM_WINDOWS];
  logic                       hist_shift;
  logic [HISTORY_DEPTH-1:0]   match;
  logic [VOTE_W-1:0]          votes;
  logic                       vote_ok;
  logic                       cur_button;

  assign sample.ready = (state == ST_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign load         = (state == ST_DONE) && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RST_SCREEN_WIDTH;
      screen_height <= RST_SCREEN_HEIGHT;
      point_offset  <= RST_POINT_OFFSET;
      edit_mode     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        REG_POINT_OFFSET:  point_offset  <= cfg_data[OFFSET_W-1:0];
        REG_EDIT_MODE:     edit_mode     <= cfg_data[0];
      endcase
    end
  end

  always_comb begin
    wr.en     = accept && (sample.operation == OP_TABLE_WRITE);
    wr.index  = sample.entry_index;
    wr.left   = sample.win_left;
    wr.top    = sample.win_top;
    wr.width  = sample.win_width;
    wr.height = sample.win_height;
    wr.flags  = sample.win_flags;
  end

  assign px_calc = POINT_W'({1'b0, prod_x[PROD_W-1:SCALE_SHIFT]})
                   - POINT_W'({1'b0, point_offset});
  assign py_calc = POINT_W'({1'b0, prod_y[PROD_W-1:SCALE_SHIFT]})
                   - POINT_W'({1'b0, point_offset});

  always_comb begin
    chain[0].valid = (state == ST_POINT) && !edit_mode;
    chain[0].x     = px_calc;
    chain[0].y     = py_calc;
    chain[0].hit   = REGION_NONE;
  end

  for (genvar g = 0; g < NUM_WINDOWS; g++) begin : g_cell
    grvt_cell #(
      .INDEX (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr        (wr),
      .probe_in  (chain[g]),
      .probe_out (chain[g+1]),
      .kind      (kinds[g])
    );
  end

  assign hist_shift = (state == ST_SCAN) && chain[NUM_WINDOWS].valid;

  grvt_history #(
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk    (clk),
    .rst    (rst),
    .shift  (hist_shift),
    .hit_in (chain[NUM_WINDOWS].hit),
    .match  (match)
  );

  always_comb begin
    votes = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      votes = votes + VOTE_W'(match[i]);
    end
    vote_ok    = (32'(votes) >= 32'(MIN_REPEAT));
    cur_button = current_region[REGION_W-1] ? 1'b0
                 : kinds[current_region[IDX_W-1:0]][FLAG_BUTTON];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      current_region <= REGION_NONE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (sample.operation == OP_TABLE_WRITE) begin
              state <= ST_DONE;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL:   state <= ST_POINT;
        ST_POINT: state <= edit_mode ? ST_DONE : ST_SCAN;
        ST_SCAN: begin
          if (chain[NUM_WINDOWS].valid) begin
            state <= ST_VOTE;
          end
        end
        ST_VOTE: begin
          if ((res_hit != current_region) && vote_ok) begin
            current_region <= res_hit;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_x       <= {1'b0, sample.left_eye_x} + {1'b0, sample.right_eye_x};
      sum_y       <= {1'b0, sample.left_eye_y} + {1'b0, sample.right_eye_y};
      res_px      <= '0;
      res_py      <= '0;
      res_hit     <= REGION_NONE;
      res_changed <= 1'b0;
      res_left    <= REGION_NONE;
      res_button  <= 1'b0;
    end
    if (state == ST_MUL) begin
      prod_x <= PROD_W'(screen_width) * PROD_W'(sum_x);
      prod_y <= PROD_W'(screen_height) * PROD_W'(sum_y);
    end
    if (state == ST_POINT) begin
      res_px <= px_calc;
      res_py <= py_calc;
    end
    if (hist_shift) begin
      res_hit <= chain[NUM_WINDOWS].hit;
    end
    if ((state == ST_VOTE) && (res_hit != current_region) && vote_ok) begin
      res_changed <= 1'b1;
      res_left    <= current_region;
      res_button  <= cur_button;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_px      <= res_px;
      out_py      <= res_py;
      out_hit     <= res_hit;
      out_changed <= res_changed;
      out_left    <= res_left;
      out_button  <= res_button;
      out_entered <= current_region;
    end
  end

  assign result.valid           = out_valid;
  assign result.point_x         = out_px;
  assign result.point_y         = out_py;
  assign result.hit_region      = out_hit;
  assign result.region_changed  = out_changed;
  assign result.region_left     = out_left;
  assign result.left_was_button = out_button;
  assign result.region_entered  = out_entered;

endmodule
`default_nettype wire

// ===== hdl/grvt_cell.sv =====
`default_nettype none
module grvt_cell #(
  parameter int INDEX = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire grvt_pkg::tbl_wr_t         wr,
  input  wire grvt_pkg::probe_t          probe_in,
  output grvt_pkg::probe_t               probe_out,
  output logic [grvt_pkg::FLAGS_W-1:0]   kind
);
  import grvt_pkg::*;

  logic [COORD_W-1:0]       left;
  logic [COORD_W-1:0]       top;
  logic [COORD_W-1:0]       width;
  logic [COORD_W-1:0]       height;
  logic                     sel;
  logic signed [POINT_W:0]  xs;
  logic signed [POINT_W:0]  ys;
  logic signed [POINT_W:0]  l;
  logic signed [POINT_W:0]  t;
  logic signed [POINT_W:0]  r;
  logic signed [POINT_W:0]  b;
  logic                     in_rect;
  probe_t                   probe_next;

  assign sel = wr.en && (wr.index == IDX_W'(INDEX));

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= '0;
    end else if (sel) begin
      kind <= wr.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      left   <= wr.left;
      top    <= wr.top;
      width  <= wr.width;
      height <= wr.height;
    end
  end

  always_comb begin
    xs      = {probe_in.x[POINT_W-1], probe_in.x};
    ys      = {probe_in.y[POINT_W-1], probe_in.y};
    l       = {2'b00, left};
    t       = {2'b00, top};
    r       = {1'b0, {1'b0, left} + {1'b0, width}};
    b       = {1'b0, {1'b0, top} + {1'b0, height}};
    in_rect = (l <= xs) && (xs <= r) && (t <= ys) && (ys <= b);
    probe_next = probe_in;
    if (probe_in.hit[REGION_W-1] && kind[FLAG_ELIGIBLE] && in_rect) begin
      probe_next.hit = REGION_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out <= probe_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/grvt_history.sv =====
`default_nettype none
module grvt_history #(
  parameter int DEPTH = 5
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             shift,
  input  wire logic signed [grvt_pkg::REGION_W-1:0] hit_in,
  output logic [DEPTH-1:0]                      match
);
  import grvt_pkg::*;

  logic signed [REGION_W-1:0] entries [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries[i] <= REGION_NONE;
      end
    end else if (shift) begin
      entries[0] <= hit_in;
      for (int i = 1; i < DEPTH; i++) begin
        entries[i] <= entries[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      match[0] <= 1'b1;
      for (int i = 1; i < DEPTH; i++) begin
        match[i] <= (entries[i-1] == hit_in);
      end
    end
  end

endmodule
`default_nettype wire
